// ===== hdl/qmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_pkg
// Shared types and constants of the quaternion multiply and divide unit.
// ----------------------------------------------------------------------------
package qmd_pkg;

  // Fraction bits of the fixed-point components.
  localparam int FRAC_BITS = 12;

  // Operand width after conjugation (negating -32768 needs one more bit).
  localparam int OPW = 17;
  // Width of one partial product and of a four-term sum.
  localparam int PW  = 2 * OPW;
  localparam int SW  = 34;
  // Width of the squared norm.
  localparam int NW  = 33;
  // Quotient bits kept before saturation.
  localparam int QB  = 17;
  // Dividend and compare widths of the long division.
  localparam int DW  = SW + FRAC_BITS;
  localparam int CW  = NW + QB + 1;

  // Operation codes.
  localparam logic [1:0] KIND_MUL   = 2'd0;
  localparam logic [1:0] KIND_DIV_B = 2'd1;
  localparam logic [1:0] KIND_DIV_A = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] res_w;
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic signed [15:0] res_z;
    logic               zero_norm;
    logic               saturated;
  } out_t;

  // Classified operation: left and right operands, already conjugated.
  typedef struct packed {
    logic                  div;
    logic                  nsel;  // 1: norm of left operand, 0: of right
    logic signed [OPW-1:0] pw;
    logic signed [OPW-1:0] px;
    logic signed [OPW-1:0] py;
    logic signed [OPW-1:0] pz;
    logic signed [OPW-1:0] qw;
    logic signed [OPW-1:0] qx;
    logic signed [OPW-1:0] qy;
    logic signed [OPW-1:0] qz;
  } op_t;

endpackage

// ===== hdl/quaternion_multiply_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_multiply_divide
// Quaternion product and quotient unit in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: each input transaction on in_valid_i/in_ready_o carries two
// quaternions A and B and an operation kind: A*B, A*B^-1 or A^-1*B.
// Each produces exactly one output transaction on out_valid_o/out_ready_i
// with four saturated components and the zero_norm and saturated flags.
// The front classifies the transaction and conjugates the operand to
// invert; a two-entry queue feeds the back pipeline.
// Throughput is one transaction per cycle while the receiver is not stalling.
// An accepted transaction passes the queue, whose output feeds the products
// directly, then sums, setup, seventeen long-division stages (one quotient bit
// per stage) and the output register. Products pass the division stages
// unchanged.
// When the receiver stalls, the whole back pipeline holds, the queue fills
// and in_ready_o drops; no transaction is lost.
// Reset empties the queue and clears all pipeline valid bits.
// ----------------------------------------------------------------------------
module quaternion_multiply_divide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qmd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qmd_pkg::out_t out_data_o
);
  import qmd_pkg::*;

  op_t  f_op, q_op;
  logic push, full, pop, q_valid;

  // Front: accept and classify.
  qmd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .op_o       (f_op)
  );

  // Queue between front and back.
  qmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (f_op),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_op)
  );

  // Back: arithmetic pipeline.
  qmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .op_i        (q_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/qmd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_front
// Accepts input transactions and classifies them into conjugated operands.
// ----------------------------------------------------------------------------
module qmd_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qmd_pkg::in_t  in_data_i,
  output logic          push_o,
  input  logic          full_i,
  output qmd_pkg::op_t  op_o
);
  import qmd_pkg::*;

  // Accept whenever the queue has room.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Pick the operands; the quaternion to invert is conjugated here.
  always_comb begin
    logic conj_a;
    logic conj_b;
    conj_a    = (in_data_i.kind == KIND_DIV_A);
    conj_b    = (in_data_i.kind == KIND_DIV_B);
    op_o.div  = conj_a || conj_b;
    op_o.nsel = conj_a;
    op_o.pw   = OPW'(in_data_i.a_w);
    op_o.px   = conj_a ? -OPW'(in_data_i.a_x) : OPW'(in_data_i.a_x);
    op_o.py   = conj_a ? -OPW'(in_data_i.a_y) : OPW'(in_data_i.a_y);
    op_o.pz   = conj_a ? -OPW'(in_data_i.a_z) : OPW'(in_data_i.a_z);
    op_o.qw   = OPW'(in_data_i.b_w);
    op_o.qx   = conj_b ? -OPW'(in_data_i.b_x) : OPW'(in_data_i.b_x);
    op_o.qy   = conj_b ? -OPW'(in_data_i.b_y) : OPW'(in_data_i.b_y);
    op_o.qz   = conj_b ? -OPW'(in_data_i.b_z) : OPW'(in_data_i.b_z);
  end

endmodule

// ===== hdl/qmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_fifo
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module qmd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  qmd_pkg::op_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output qmd_pkg::op_t rdata_o
);
  import qmd_pkg::*;

  op_t        mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/qmd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_back
// Multiply, sum, long-division and saturation pipeline with output register.
// ----------------------------------------------------------------------------
module qmd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  qmd_pkg::op_t  op_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qmd_pkg::out_t out_data_o
);
  import qmd_pkg::*;

  typedef struct packed {
    logic                 div;
    logic [15:0][PW-1:0]  m;
    logic [3:0][PW-1:0]   sq;
  } s1_t;

  typedef struct packed {
    logic                 div;
    logic [3:0][SW-1:0]   s;
    logic [NW-1:0]        n;
  } s2_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [QB-1:0] q;
    logic [DW-1:0] rem;
  } lane_t;

  typedef struct packed {
    logic              div;
    logic              zn;
    logic [NW-1:0]     n;
    logic [3:0][$bits(lane_t)-1:0] ln;
  } dv_t;

  logic            en;
  logic            v1_q, v2_q;
  logic [QB:0]     vd_q;
  logic            vo_q;
  s1_t             s1_q, s1_d;
  s2_t             s2_q, s2_d;
  dv_t             dv_q [QB+1];
  dv_t             dv_d [QB+1];
  out_t            out_q, out_d;

  // The whole pipeline advances unless a held result blocks the output.
  assign en          = !vo_q || out_ready_i;
  assign pop_o       = en && valid_i;
  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // Stage 1: partial products and squares.
  always_comb begin
    logic signed [OPW-1:0] nw, nx, ny, nz;
    s1_d.div  = op_i.div;
    s1_d.m[0]  = PW'(op_i.pw * op_i.qw);
    s1_d.m[1]  = PW'(op_i.px * op_i.qx);
    s1_d.m[2]  = PW'(op_i.py * op_i.qy);
    s1_d.m[3]  = PW'(op_i.pz * op_i.qz);
    s1_d.m[4]  = PW'(op_i.pw * op_i.qx);
    s1_d.m[5]  = PW'(op_i.px * op_i.qw);
    s1_d.m[6]  = PW'(op_i.py * op_i.qz);
    s1_d.m[7]  = PW'(op_i.pz * op_i.qy);
    s1_d.m[8]  = PW'(op_i.pw * op_i.qy);
    s1_d.m[9]  = PW'(op_i.py * op_i.qw);
    s1_d.m[10] = PW'(op_i.pz * op_i.qx);
    s1_d.m[11] = PW'(op_i.px * op_i.qz);
    s1_d.m[12] = PW'(op_i.pw * op_i.qz);
    s1_d.m[13] = PW'(op_i.pz * op_i.qw);
    s1_d.m[14] = PW'(op_i.px * op_i.qy);
    s1_d.m[15] = PW'(op_i.py * op_i.qx);
    nw = op_i.nsel ? op_i.pw : op_i.qw;
    nx = op_i.nsel ? op_i.px : op_i.qx;
    ny = op_i.nsel ? op_i.py : op_i.qy;
    nz = op_i.nsel ? op_i.pz : op_i.qz;
    s1_d.sq[0] = PW'(nw * nw);
    s1_d.sq[1] = PW'(nx * nx);
    s1_d.sq[2] = PW'(ny * ny);
    s1_d.sq[3] = PW'(nz * nz);
  end

  // Stage 2: four-term sums of the Hamilton product and the squared norm.
  always_comb begin
    logic [PW-1:0] nsum;
    s2_d.div  = s1_q.div;
    s2_d.s[0] = SW'(s1_q.m[0] - s1_q.m[1] - s1_q.m[2] - s1_q.m[3]);
    s2_d.s[1] = SW'(s1_q.m[4] + s1_q.m[5] + s1_q.m[6] - s1_q.m[7]);
    s2_d.s[2] = SW'(s1_q.m[8] + s1_q.m[9] + s1_q.m[10] - s1_q.m[11]);
    s2_d.s[3] = SW'(s1_q.m[12] + s1_q.m[13] + s1_q.m[14] - s1_q.m[15]);
    nsum      = s1_q.sq[0] + s1_q.sq[1] + s1_q.sq[2] + s1_q.sq[3];
    s2_d.n    = nsum[NW-1:0];
  end

  // Stage 3: magnitudes, dividend setup and overflow check.
  always_comb begin
    lane_t         l;
    logic [SW-1:0] mag;
    logic [CW-1:0] lim;
    dv_d[0].div = s2_q.div;
    dv_d[0].zn  = s2_q.div && (s2_q.n == '0);
    dv_d[0].n   = s2_q.n;
    lim         = CW'(s2_q.n) << QB;
    for (int i = 0; i < 4; i++) begin
      l.neg = s2_q.s[i][SW-1];
      mag   = l.neg ? (~s2_q.s[i] + SW'(1)) : s2_q.s[i];
      if (s2_q.div) begin
        l.rem = {mag, {FRAC_BITS{1'b0}}};
        l.ovf = (CW'(l.rem) >= lim);
        l.q   = '0;
      end else begin
        l.rem = '0;
        l.ovf = |mag[SW-1:FRAC_BITS+QB];
        l.q   = mag[FRAC_BITS+QB-1:FRAC_BITS];
      end
      dv_d[0].ln[i] = l;
    end
  end

  // Division stages: one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    always_comb begin
      lane_t         l;
      logic [CW-1:0] trial;
      dv_d[j+1] = dv_q[j];
      trial     = CW'(dv_q[j].n) << (QB - 1 - j);
      for (int i = 0; i < 4; i++) begin
        l = dv_q[j].ln[i];
        if (dv_q[j].div && (CW'(l.rem) >= trial)) begin
          l.rem          = l.rem - trial[DW-1:0];
          l.q[QB-1-j]    = 1'b1;
        end
        dv_d[j+1].ln[i] = l;
      end
    end
  end

  // Signed saturation of one lane.
  function automatic logic [16:0] clip(lane_t l);
    logic [15:0] r;
    logic        s;
    if (l.neg) begin
      s = l.ovf || (l.q > QB'(32768));
      r = s ? 16'h8000 : 16'(~l.q + QB'(1));
    end else begin
      s = l.ovf || (l.q > QB'(32767));
      r = s ? 16'h7fff : l.q[15:0];
    end
    return {r, s};
  endfunction

  // Output stage: saturation, sign and zero-norm handling.
  always_comb begin
    logic [3:0][16:0] c;
    for (int i = 0; i < 4; i++) begin
      c[i] = clip(lane_t'(dv_q[QB].ln[i]));
    end
    if (dv_q[QB].zn) begin
      out_d = '0;
      out_d.zero_norm = 1'b1;
    end else begin
      out_d.res_w     = c[0][16:1];
      out_d.res_x     = c[1][16:1];
      out_d.res_y     = c[2][16:1];
      out_d.res_z     = c[3][16:1];
      out_d.zero_norm = 1'b0;
      out_d.saturated = c[0][0] | c[1][0] | c[2][0] | c[3][0];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vd_q <= '0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      vd_q <= {vd_q[QB-1:0], v2_q};
      vo_q <= vd_q[QB];
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      out_q <= out_d;
      for (int k = 0; k <= QB; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

endmodule
